/* design/lxfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_pkg
// Shared types and constants for the length-prefixed XOR frame receiver.
// ----------------------------------------------------------------------------
package lxfr_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int LEN_W       = ADDR_W + 1;
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);

  localparam logic [7:0] RX_TIMEOUT_RESET = 8'd47;
  localparam logic [7:0] GUARD_RESET      = 8'd21;

  localparam logic CFG_RX_TIMEOUT = 1'b0;
  localparam logic CFG_GUARD      = 1'b1;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    KIND_BYTE    = 3'd0,
    KIND_CSUM    = 3'd1,
    KIND_LEN     = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_RELEASE = 3'd4
  } kind_t;

  // work handed from front to back
  typedef struct packed {
    logic             frame;
    kind_t            kind;
    logic             rel;
    logic             bank;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W:0]   addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } done_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REL,
    BK_READ,
    BK_WAIT
  } bk_state_t;

  function automatic logic [7:0] load_value(input logic [7:0] r);
    return (r == 8'd0) ? 8'd1 : r;
  endfunction

endpackage

/* design/length_xor_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_xor_frame_receiver_top
// Length-prefixed serial frame receiver with XOR check, status reporting and
// bus guard timing.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | push / full          | action, data, byte_error
//  result   | empty / pop          | kind, data_res, last, bus_busy
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  The front end takes an item when push is high and full is low; status
//  results leave one a cycle while pop keeps the output register free, frame
//  bytes pass a store read, then the output register. full rises while the
//  command queue is full or the next bank to write still holds a queued frame.
//  Synchronous reset; no clearing pass, the store needs none.
// ----------------------------------------------------------------------------
module length_xor_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       action,
  input  logic [7:0] data,
  input  logic       byte_error,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind,
  output logic [7:0] data_res,
  output logic       last,
  output logic       bus_busy,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic             q_full;
  logic             q_empty;
  logic             cmd_push;
  logic             cmd_pop;
  lxfr_pkg::cmd_t   cmd;
  lxfr_pkg::cmd_t   head;
  lxfr_pkg::wr_t    wr;
  lxfr_pkg::done_t  done;

  lxfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .data       (data),
    .byte_error (byte_error),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .done       (done),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .wr         (wr)
  );

  lxfr_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .push   (cmd_push),
    .cmd_in (cmd),
    .pop    (cmd_pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  lxfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .q_empty  (q_empty),
    .head     (head),
    .cmd_pop  (cmd_pop),
    .done     (done),
    .pop      (pop),
    .empty    (empty),
    .kind     (kind),
    .data_res (data_res),
    .last     (last),
    .bus_busy (bus_busy)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.frame) |->
      (cmd.len >= lxfr_pkg::LEN_W'(2)) &&
      (cmd.len <= lxfr_pkg::LEN_W'(lxfr_pkg::MAX_FRAME)))
    else $error("frame command with bad length");

  a_done_has_cmd: assert property (@(posedge clk) disable iff (rst)
    done.en |-> (!q_empty && head.frame && cmd_pop))
    else $error("frame drain finished without a frame command");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind != lxfr_pkg::KIND_BYTE)) |->
      (last && (data_res == 8'd0) && !bus_busy))
    else $error("status result with bad fields");

endmodule

/* design/lxfr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_front
// Accepts bytes and ticks, tracks frame state and timers, writes the frame
// store and queues frame and status commands for the back end.
// ----------------------------------------------------------------------------
module lxfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              action,
  input  logic [7:0]        data,
  input  logic              byte_error,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              q_full,
  input  lxfr_pkg::done_t   done,
  output logic              cmd_push,
  output lxfr_pkg::cmd_t    cmd,
  output lxfr_pkg::wr_t     wr
);

  logic [7:0]                 rx_timeout_chars;
  logic [7:0]                 guard_chars;
  logic [lxfr_pkg::CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]                 running_xor, running_xor_next;
  logic [7:0]                 second_byte, second_byte_next;
  logic                       receiving, receiving_next;
  logic [7:0]                 frame_timer, frame_timer_next;
  logic [7:0]                 guard_timer, guard_timer_next;
  logic                       busy, busy_next;
  logic                       wbank, wbank_next;
  logic [1:0]                 pend, pend_next;

  logic                       accept;
  logic [lxfr_pkg::CNT_W-1:0] cnt_v;
  logic [7:0]                 xor_v;
  logic [7:0]                 sec_v;
  logic [8:0]                 len_v;
  logic                       have2;
  logic [7:0]                 rx_t;
  logic [7:0]                 guard_t;
  logic                       tmo;
  logic                       rel;
  logic                       set_pend;

  assign full      = q_full || pend[wbank];
  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  always_comb begin
    cnt_v = byte_count;
    xor_v = running_xor;
    sec_v = second_byte;
    wr    = '0;
    if (!byte_error) begin
      wr.en   = accept && (action == lxfr_pkg::ACT_BYTE);
      wr.addr = {wbank, byte_count[lxfr_pkg::ADDR_W-1:0]};
      wr.data = data;
      cnt_v   = byte_count + lxfr_pkg::CNT_W'(1);
      xor_v   = running_xor ^ data;
      if (byte_count == lxfr_pkg::CNT_W'(1)) begin
        sec_v = data;
      end
    end
    len_v   = {1'b0, sec_v} + 9'd2;
    have2   = cnt_v >= lxfr_pkg::CNT_W'(2);
    rx_t    = frame_timer - {7'd0, (frame_timer != 8'd0)};
    guard_t = guard_timer - 8'd1;
    tmo     = receiving && (rx_t == 8'd0);
    rel     = (guard_timer != 8'd0) && (guard_t == 8'd0);
  end

  always_comb begin
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    second_byte_next = second_byte;
    receiving_next   = receiving;
    frame_timer_next = frame_timer;
    guard_timer_next = guard_timer;
    busy_next        = busy;
    wbank_next       = wbank;
    set_pend         = 1'b0;
    cmd_push         = 1'b0;
    cmd              = '0;
    if (accept) begin
      if (action == lxfr_pkg::ACT_BYTE) begin
        busy_next        = 1'b1;
        byte_count_next  = cnt_v;
        running_xor_next = xor_v;
        second_byte_next = sec_v;
        if (have2 && (len_v > 9'(lxfr_pkg::MAX_FRAME))) begin
          cmd_push         = 1'b1;
          cmd.kind         = lxfr_pkg::KIND_LEN;
          byte_count_next  = '0;
          running_xor_next = '0;
          receiving_next   = 1'b0;
          busy_next        = 1'b0;
        end else if (have2 && ({2'b00, cnt_v} >= len_v)) begin
          cmd_push       = 1'b1;
          receiving_next = 1'b0;
          if (xor_v != 8'd0) begin
            cmd.kind  = lxfr_pkg::KIND_CSUM;
            busy_next = 1'b0;
          end else begin
            cmd.frame        = 1'b1;
            cmd.kind         = lxfr_pkg::KIND_BYTE;
            cmd.bank         = wbank;
            cmd.len          = len_v[lxfr_pkg::LEN_W-1:0];
            guard_timer_next = lxfr_pkg::load_value(guard_chars);
            wbank_next       = ~wbank;
            set_pend         = 1'b1;
          end
          byte_count_next  = '0;
          running_xor_next = '0;
        end else begin
          receiving_next   = 1'b1;
          frame_timer_next = lxfr_pkg::load_value(rx_timeout_chars);
        end
      end else begin
        if (receiving) begin
          frame_timer_next = rx_t;
        end
        if (tmo) begin
          receiving_next   = 1'b0;
          busy_next        = 1'b0;
          byte_count_next  = '0;
          running_xor_next = '0;
        end
        if (guard_timer != 8'd0) begin
          guard_timer_next = guard_t;
        end
        if (rel) begin
          busy_next = 1'b0;
        end
        cmd_push = tmo || rel;
        cmd.kind = tmo ? lxfr_pkg::KIND_TIMEOUT : lxfr_pkg::KIND_RELEASE;
        cmd.rel  = tmo && rel;
      end
    end
  end

  always_comb begin
    pend_next = pend;
    if (done.en) begin
      pend_next[done.bank] = 1'b0;
    end
    if (set_pend) begin
      pend_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_timeout_chars <= lxfr_pkg::RX_TIMEOUT_RESET;
      guard_chars      <= lxfr_pkg::GUARD_RESET;
      byte_count       <= '0;
      running_xor      <= '0;
      second_byte      <= '0;
      receiving        <= 1'b0;
      frame_timer      <= '0;
      guard_timer      <= '0;
      busy             <= 1'b0;
      wbank            <= 1'b0;
      pend             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lxfr_pkg::CFG_RX_TIMEOUT: rx_timeout_chars <= cfg_data;
          lxfr_pkg::CFG_GUARD:      guard_chars      <= cfg_data;
          default:                  ;
        endcase
      end
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
      second_byte <= second_byte_next;
      receiving   <= receiving_next;
      frame_timer <= frame_timer_next;
      guard_timer <= guard_timer_next;
      busy        <= busy_next;
      wbank       <= wbank_next;
      pend        <= pend_next;
    end
  end

endmodule

/* design/lxfr_cmdq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_cmdq
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module lxfr_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lxfr_pkg::cmd_t cmd_in,
  input  logic           pop,
  output lxfr_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  lxfr_pkg::cmd_t               slots [lxfr_pkg::CMDQ_DEPTH];
  logic [lxfr_pkg::CMDQ_AW-1:0] wp;
  logic [lxfr_pkg::CMDQ_AW-1:0] rp;
  logic [lxfr_pkg::CMDQ_AW:0]   cnt;
  logic                         do_push;
  logic                         do_pop;

  assign empty   = (cnt == '0);
  assign full    = (cnt == (lxfr_pkg::CMDQ_AW+1)'(lxfr_pkg::CMDQ_DEPTH));
  assign head    = slots[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + lxfr_pkg::CMDQ_AW'(1);
      end
      if (do_pop) begin
        rp <= rp + lxfr_pkg::CMDQ_AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + (lxfr_pkg::CMDQ_AW+1)'(1);
        2'b01:   cnt <= cnt - (lxfr_pkg::CMDQ_AW+1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* design/lxfr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxfr_back
// Holds the two-bank frame store, runs queued commands and drives the
// result output register.
// ----------------------------------------------------------------------------
module lxfr_back (
  input  logic           clk,
  input  logic           rst,
  input  lxfr_pkg::wr_t  wr,
  input  logic           q_empty,
  input  lxfr_pkg::cmd_t head,
  output logic           cmd_pop,
  output lxfr_pkg::done_t done,
  input  logic           pop,
  output logic           empty,
  output logic [2:0]     kind,
  output logic [7:0]     data_res,
  output logic           last,
  output logic           bus_busy
);

  logic [7:0] store [2*lxfr_pkg::STORE_DEPTH];
  logic [7:0] rd_data;
  logic       rd_en;

  lxfr_pkg::bk_state_t         state, state_next;
  logic [lxfr_pkg::ADDR_W-1:0] idx;
  logic                        out_valid;
  lxfr_pkg::kind_t             out_kind;
  logic [7:0]                  out_data;
  logic                        out_last;

  logic                        free;
  logic                        at_last;
  logic                        load_out;
  lxfr_pkg::kind_t             ld_kind;
  logic [7:0]                  ld_data;
  logic                        ld_last;
  logic                        idx_inc;

  assign free    = !out_valid || pop;
  assign at_last = (lxfr_pkg::LEN_W'(idx) + lxfr_pkg::LEN_W'(1)) == head.len;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= store[{head.bank, idx}];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lxfr_pkg::BK_IDLE: begin
        if (!q_empty && free) begin
          if (head.frame) begin
            state_next = lxfr_pkg::BK_READ;
          end else if (head.rel) begin
            state_next = lxfr_pkg::BK_REL;
          end
        end
      end
      lxfr_pkg::BK_REL: begin
        if (free) begin
          state_next = lxfr_pkg::BK_IDLE;
        end
      end
      lxfr_pkg::BK_READ: begin
        if (free) begin
          state_next = lxfr_pkg::BK_WAIT;
        end
      end
      lxfr_pkg::BK_WAIT: begin
        state_next = at_last ? lxfr_pkg::BK_IDLE : lxfr_pkg::BK_READ;
      end
      default: state_next = lxfr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    done     = '0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    ld_kind  = lxfr_pkg::KIND_BYTE;
    ld_data  = 8'd0;
    ld_last  = 1'b1;
    idx_inc  = 1'b0;
    unique case (state)
      lxfr_pkg::BK_IDLE: begin
        if (!q_empty && free && !head.frame) begin
          cmd_pop  = 1'b1;
          load_out = 1'b1;
          ld_kind  = head.kind;
        end
      end
      lxfr_pkg::BK_REL: begin
        if (free) begin
          load_out = 1'b1;
          ld_kind  = lxfr_pkg::KIND_RELEASE;
        end
      end
      lxfr_pkg::BK_READ: begin
        rd_en = free;
      end
      lxfr_pkg::BK_WAIT: begin
        load_out = 1'b1;
        ld_kind  = lxfr_pkg::KIND_BYTE;
        ld_data  = rd_data;
        ld_last  = at_last;
        idx_inc  = !at_last;
        cmd_pop  = at_last;
        done.en  = at_last;
        done.bank = head.bank;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lxfr_pkg::BK_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (idx_inc) begin
        idx <= idx + lxfr_pkg::ADDR_W'(1);
      end else if (done.en) begin
        idx <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kind <= ld_kind;
      out_data <= ld_data;
      out_last <= ld_last;
    end
  end

  assign empty    = !out_valid;
  assign kind     = out_kind;
  assign data_res = out_data;
  assign last     = out_last;
  assign bus_busy = (out_kind == lxfr_pkg::KIND_BYTE);

endmodule

/* sim/tb_length_xor_frame_receiver_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_xor_frame_receiver_top
// Self-checking bench for the length-prefixed XOR frame receiver. Byte and
// tick items go in through the push/full queue and results are popped and
// compared with a behavioural copy of the receiver kept in the bench. Covers
// good, checksum, length and timeout cases, guard release and timer settings
// from zero to 255, with random idling on both queue sides.
// ----------------------------------------------------------------------------
module tb_length_xor_frame_receiver_top;

  typedef struct {
    lxfr_pkg::kind_t kind;
    logic [7:0]      byte_val;
    logic            last;
    logic            busy;
  } rx_result_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic       action = lxfr_pkg::ACT_TICK;
  logic [7:0] data = 8'h00;
  logic       byte_error = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [2:0] kind;
  logic [7:0] data_res;
  logic       last;
  logic       bus_busy;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = lxfr_pkg::CFG_RX_TIMEOUT;
  logic [7:0] cfg_data = 8'h00;

  length_xor_frame_receiver_top u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .data       (data),
    .byte_error (byte_error),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .data_res   (data_res),
    .last       (last),
    .bus_busy   (bus_busy),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // receiver copy
  logic [7:0] rx_limit = lxfr_pkg::RX_TIMEOUT_RESET;
  logic [7:0] guard_len = lxfr_pkg::GUARD_RESET;
  logic [7:0] store_q [lxfr_pkg::STORE_DEPTH];
  logic [6:0] cnt_q = '0;
  logic [7:0] xor_q = '0;
  logic [8:0] flen_q = '0;
  logic       in_frame = 1'b0;
  logic [7:0] rx_tmr = '0;
  logic [7:0] guard_tmr = '0;
  logic       bus_q = 1'b0;

  rx_result_t owed_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int kind_seen [5] = '{default: 0};
  bit steady = 1'b0;
  int pop_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic logic [7:0] timer_reload(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic rx_result_t status_res(input lxfr_pkg::kind_t k);
    rx_result_t r;
    r.kind = k;
    r.byte_val = 8'h00;
    r.last = 1'b1;
    r.busy = 1'b0;
    return r;
  endfunction

  task automatic clear_frame();
    cnt_q = '0;
    xor_q = '0;
    flen_q = '0;
  endtask

  task automatic receiver_step(input logic act, input logic [7:0] d, input logic err);
    rx_result_t step_q [$];
    rx_result_t r;
    int k;
    if (act == lxfr_pkg::ACT_BYTE) begin
      bus_q = 1'b1;
      if (!err) begin
        store_q[cnt_q[lxfr_pkg::ADDR_W-1:0]] = d;
        cnt_q = cnt_q + 7'd1;
        xor_q ^= d;
      end
      if (cnt_q >= 2) flen_q = {1'b0, store_q[1]} + 9'd2;
      if (cnt_q >= 2 && flen_q > lxfr_pkg::MAX_FRAME) begin
        step_q.push_back(status_res(lxfr_pkg::KIND_LEN));
        clear_frame();
        in_frame = 1'b0;
        bus_q = 1'b0;
      end else if (cnt_q >= 2 && cnt_q >= flen_q) begin
        in_frame = 1'b0;
        if (xor_q != 8'h00) begin
          step_q.push_back(status_res(lxfr_pkg::KIND_CSUM));
          bus_q = 1'b0;
        end else begin
          for (k = 0; k < flen_q; k++) begin
            r.kind = lxfr_pkg::KIND_BYTE;
            r.byte_val = store_q[k % lxfr_pkg::STORE_DEPTH];
            r.last = (k + 1 == flen_q);
            step_q.push_back(r);
          end
          guard_tmr = timer_reload(guard_len);
        end
        clear_frame();
      end else begin
        in_frame = 1'b1;
        rx_tmr = timer_reload(rx_limit);
      end
    end else begin
      if (in_frame) begin
        if (rx_tmr > 0) rx_tmr--;
        if (rx_tmr == 0) begin
          step_q.push_back(status_res(lxfr_pkg::KIND_TIMEOUT));
          in_frame = 1'b0;
          bus_q = 1'b0;
          clear_frame();
        end
      end
      if (guard_tmr > 0) begin
        guard_tmr--;
        if (guard_tmr == 0) begin
          bus_q = 1'b0;
          step_q.push_back(status_res(lxfr_pkg::KIND_RELEASE));
        end
      end
    end
    foreach (step_q[i]) begin
      step_q[i].busy = bus_q;
      owed_results.push_back(step_q[i]);
    end
  endtask

  // push stays high across back-to-back items; lowered only ahead of a gap
  task automatic send_item(input logic act, input logic [7:0] d, input logic err);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    data <= d;
    byte_error <= err;
    do @(posedge clk); while (full);
    receiver_step(act, d, err);
    items_sent++;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_timers(input logic [7:0] rx_v, input logic [7:0] guard_v);
    cfg_valid <= 1'b1;
    cfg_index <= lxfr_pkg::CFG_RX_TIMEOUT;
    cfg_data <= rx_v;
    do @(posedge clk); while (!cfg_ready);
    rx_limit = rx_v;
    cfg_index <= lxfr_pkg::CFG_GUARD;
    cfg_data <= guard_v;
    do @(posedge clk); while (!cfg_ready);
    guard_len = guard_v;
    cfg_valid <= 1'b0;
  endtask

  function automatic bit field_ok(input string name, input int want, input int got);
    if (want != got)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return want == got;
  endfunction

  task automatic check_result();
    rx_result_t e;
    results_seen++;
    if (owed_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual kind %0d data %0d",
               $time, kind, data_res);
      errors++;
    end else begin
      e = owed_results.pop_front();
      kind_seen[int'(e.kind)]++;
      if (!field_ok("kind", int'(e.kind), kind)) errors++;
      if (!field_ok("data_res", e.byte_val, data_res)) errors++;
      if (!field_ok("last", e.last, last)) errors++;
      if (!field_ok("bus_busy", e.busy, bus_busy)) errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_result();
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (!steady) pop_hold = idle_len();
    end
  end

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(2, 8);
    if (r < 97) return $urandom_range(9, 30);
    return $urandom_range(31, lxfr_pkg::MAX_FRAME);
  endfunction

  task automatic send_frame(input int len, input bit bad_sum);
    logic [7:0] fb [$];
    logic [7:0] acc;
    int i;
    acc = 8'h00;
    if (len == 2) begin
      fb.push_back(bad_sum ? 8'($urandom_range(1, 255)) : 8'h00);
      fb.push_back(8'h00);
    end else begin
      fb.push_back(8'($urandom));
      fb.push_back(8'(len - 2));
      for (i = 2; i < len - 1; i++) fb.push_back(8'($urandom));
      foreach (fb[j]) acc ^= fb[j];
      fb.push_back(acc ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00));
    end
    foreach (fb[j]) begin
      if ($urandom_range(0, 19) == 0)
        send_item(lxfr_pkg::ACT_BYTE, 8'($urandom), 1'b1);
      else if ($urandom_range(0, 19) == 0)
        send_item(lxfr_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
      send_item(lxfr_pkg::ACT_BYTE, fb[j], 1'b0);
    end
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(lxfr_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_mix(input int n_items);
    int start;
    int pick;
    int n;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_frame(pick_len(), 1'b0);
      end else if (pick < 55) begin
        send_frame(pick_len(), 1'b1);
      end else if (pick < 62) begin
        send_item(lxfr_pkg::ACT_BYTE, 8'($urandom), 1'b0);
        send_item(lxfr_pkg::ACT_BYTE, 8'($urandom_range(lxfr_pkg::MAX_FRAME - 1, 255)),
                  1'b0);
      end else if (pick < 72) begin
        // partial frame left to stall
        send_item(lxfr_pkg::ACT_BYTE, 8'($urandom), 1'b0);
        send_item(lxfr_pkg::ACT_BYTE, 8'($urandom_range(3, lxfr_pkg::MAX_FRAME - 2)),
                  1'b0);
        if ($urandom_range(0, 1)) send_item(lxfr_pkg::ACT_BYTE, 8'($urandom), 1'b0);
        n = (rx_limit <= 20) ? timer_reload(rx_limit) : $urandom_range(1, 5);
        send_ticks(n);
      end else if (pick < 85) begin
        send_ticks($urandom_range(1, (guard_len <= 16) ? guard_len + 1 : 4));
      end else begin
        send_item(lxfr_pkg::ACT_BYTE, 8'($urandom), 1'($urandom));
      end
      if ($urandom_range(0, 29) == 0) settle();
    end
  endtask

  task automatic test_default_timers();
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'hFF, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h03, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'hFC, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h01, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h55, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'hFF, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'hAA, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h3F, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h12, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'hFF, 1'b1);
    send_item(lxfr_pkg::ACT_BYTE, 8'h01, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h13, 1'b0);
    send_item(lxfr_pkg::ACT_TICK, 8'hFF, 1'b1);
    settle();
  endtask

  task automatic test_shortest_timers();
    set_timers(8'd0, 8'd0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_TICK, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h5A, 1'b0);
    send_item(lxfr_pkg::ACT_TICK, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h81, 1'b1);
    send_item(lxfr_pkg::ACT_TICK, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h33, 1'b0);
    send_item(lxfr_pkg::ACT_TICK, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_TICK, 8'h00, 1'b0);
    settle();
  endtask

  task automatic test_longest_timers();
    set_timers(8'd255, 8'd255);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_item(lxfr_pkg::ACT_BYTE, 8'h00, 1'b0);
    send_ticks(4);
    settle();
  endtask

  task automatic test_random_traffic();
    set_timers(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
    send_frame(lxfr_pkg::MAX_FRAME, 1'b0);
    run_mix(50);
    settle();
    set_timers(8'd0, 8'd255);
    run_mix(50);
    settle();
    set_timers(8'd255, 8'd1);
    run_mix(50);
    settle();
    set_timers(8'($urandom_range(2, 12)), 8'($urandom_range(2, 12)));
    steady = 1'b1;
    run_mix(30);
    steady = 1'b0;
    run_mix(30);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_default_timers();
    test_shortest_timers();
    test_longest_timers();
    test_random_traffic();
    settle();
    $display("%0d items in, %0d results out: %0d frame bytes, %0d checksum drops,",
             items_sent, results_seen, kind_seen[0], kind_seen[1]);
    $display("%0d length drops, %0d timeout drops, %0d bus releases, %0d errors",
             kind_seen[2], kind_seen[3], kind_seen[4], errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* length_xor_frame_receiver_top.f */
design/lxfr_pkg.sv
design/lxfr_front.sv
design/lxfr_cmdq.sv
design/lxfr_back.sv
design/length_xor_frame_receiver_top.sv
sim/tb_length_xor_frame_receiver_top.sv
